// File: src/hsc_pkg.sv
`default_nettype none

package hsc_pkg;

    localparam int MAX_CODE_BITS = 63;
    localparam int WORD_W        = 63;
    localparam int CNT_W         = 6;
    localparam int PAR_W         = 6;
    localparam int LEN_ENTRIES   = 2 ** CNT_W;

    typedef logic [WORD_W-1:0]            word_t;
    typedef logic [CNT_W-1:0]             count_t;
    typedef logic [PAR_W-1:0]             syn_t;
    typedef count_t [LEN_ENTRIES-1:0]     len_table_t;
    typedef word_t [PAR_W-1:0]            cover_table_t;
    typedef count_t [WORD_W-1:0]          map_table_t;

    typedef enum logic {
        KIND_ENCODE = 1'b0,
        KIND_DECODE = 1'b1
    } kind_t;

    // Least r with 2^r - r >= m + 1
    function automatic int parity_count(input int m);
        int r;
        r = 0;
        while (((1 << r) - r) < (m + 1)) begin
            r++;
        end
        return r;
    endfunction

    function automatic logic is_pow2(input int x);
        return (x != 0) && ((x & (x - 1)) == 0);
    endfunction

    // Codeword length per data length, zero where the data length is unusable
    function automatic len_table_t build_enc_len();
        len_table_t t;
        int n;
        for (int m = 0; m < LEN_ENTRIES; m++) begin
            n = m + parity_count(m);
            t[m] = ((m != 0) && (n <= MAX_CODE_BITS)) ? count_t'(n) : '0;
        end
        return t;
    endfunction

    // Data length per codeword length, zero where the codeword length is unusable
    function automatic len_table_t build_dec_len();
        len_table_t t;
        int r;
        int m;
        for (int n = 0; n < LEN_ENTRIES; n++) begin
            r = 0;
            for (int p = 1; p <= n; p = p << 1) begin
                r++;
            end
            m = n - r;
            t[n] = ((n != 0) && (n <= MAX_CODE_BITS) && (m > 0) && (parity_count(m) == r))
                ? count_t'(m) : '0;
        end
        return t;
    endfunction

    // Bits of the word covered by each parity check
    function automatic cover_table_t build_cover();
        cover_table_t t;
        for (int k = 0; k < PAR_W; k++) begin
            for (int i = 0; i < WORD_W; i++) begin
                t[k][i] = (((i + 1) >> k) & 1) != 0;
            end
        end
        return t;
    endfunction

    function automatic word_t build_par_mask();
        word_t t;
        for (int i = 0; i < WORD_W; i++) begin
            t[i] = is_pow2(i + 1);
        end
        return t;
    endfunction

    // For each codeword bit, the data bit it carries (zero at parity positions)
    function automatic map_table_t build_pos_to_data();
        map_table_t t;
        int d;
        d = 0;
        for (int i = 0; i < WORD_W; i++) begin
            if (is_pow2(i + 1)) begin
                t[i] = '0;
            end else begin
                t[i] = count_t'(d);
                d++;
            end
        end
        return t;
    endfunction

    // For each data bit, the codeword bit that carries it
    function automatic map_table_t build_data_pos();
        map_table_t t;
        int d;
        t = '0;
        d = 0;
        for (int i = 0; i < WORD_W; i++) begin
            if (!is_pow2(i + 1)) begin
                t[d] = count_t'(i);
                d++;
            end
        end
        return t;
    endfunction

    function automatic word_t build_data_has();
        word_t t;
        int d;
        t = '0;
        d = 0;
        for (int i = 0; i < WORD_W; i++) begin
            if (!is_pow2(i + 1)) begin
                t[d] = 1'b1;
                d++;
            end
        end
        return t;
    endfunction

    localparam len_table_t   ENC_LEN     = build_enc_len();
    localparam len_table_t   DEC_LEN     = build_dec_len();
    localparam cover_table_t COVER       = build_cover();
    localparam word_t        PAR_MASK    = build_par_mask();
    localparam map_table_t   POS_TO_DATA = build_pos_to_data();
    localparam map_table_t   DATA_POS    = build_data_pos();
    localparam word_t        DATA_HAS    = build_data_has();

endpackage

`default_nettype wire

// File: src/hamming_sec_codec_core.sv
// Hamming single-error-correcting encoder / decoder, variable length.
// Input channel (s_valid / s_ready): s_kind selects encode or decode,
// s_word carries data or codeword bits (bit i is position i+1), s_bit_count
// gives how many of them count, s_correct asks the decoder to fix the bit the
// syndrome names.
// Result channel (m_valid / m_ready): the codeword or extracted data, its
// length, the syndrome and the error_seen, bad_syndrome and bad_length flags.
// Every input beat gives exactly one result beat, in order.
// A beat passes from the input register to the result register, which drives
// m_valid. Throughput: one beat per cycle unless m_ready stalls; the parity
// trees, correction and bit placement all sit in the single logic stage
// between the two registers.
// Reset (aresetn low, synchronous) empties both registers; s_ready is
// already high when aresetn is released.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; s_ready then drops until m_ready frees
// a place, and nothing is lost or repeated.
`default_nettype none

module hamming_sec_codec_core (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_kind,
    input  wire hsc_pkg::word_t        s_word,
    input  wire hsc_pkg::count_t       s_bit_count,
    input  wire logic                  s_correct,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output hsc_pkg::word_t             m_result_word,
    output hsc_pkg::count_t            m_result_bits,
    output hsc_pkg::syn_t              m_syndrome,
    output logic                       m_error_seen,
    output logic                       m_bad_syndrome,
    output logic                       m_bad_length
);

    // input register
    logic               in_valid_reg, in_valid_next;
    logic               kind_reg;
    hsc_pkg::word_t     word_reg;
    hsc_pkg::count_t    bit_count_reg;
    logic               correct_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    hsc_pkg::word_t     result_word_reg, result_word_next;
    hsc_pkg::count_t    result_bits_reg, result_bits_next;
    hsc_pkg::syn_t      syndrome_reg, syndrome_next;
    logic               error_seen_reg, error_seen_next;
    logic               bad_syndrome_reg, bad_syndrome_next;
    logic               bad_length_reg, bad_length_next;

    logic               out_space;
    logic               advance;
    logic               s_take;

    // datapath
    hsc_pkg::word_t     count_mask;
    hsc_pkg::word_t     enc_data;
    hsc_pkg::word_t     enc_spread;
    hsc_pkg::word_t     enc_word;
    hsc_pkg::count_t    enc_len;
    hsc_pkg::word_t     dec_cw;
    hsc_pkg::syn_t      dec_syn;
    logic               dec_bad_syn;
    hsc_pkg::word_t     dec_flip;
    hsc_pkg::word_t     dec_fixed;
    hsc_pkg::word_t     dec_data;
    hsc_pkg::count_t    dec_len;

    assign out_space = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_space;
    assign s_ready   = !in_valid_reg || out_space;
    assign s_take    = s_valid && s_ready;

    always_comb begin
        in_valid_next  = s_take || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            kind_reg      <= s_kind;
            word_reg      <= s_word;
            bit_count_reg <= s_bit_count;
            correct_reg   <= s_correct;
        end
    end

    // Bits below bit_count are meaningful
    always_comb begin
        for (int i = 0; i < hsc_pkg::WORD_W; i++) begin
            count_mask[i] = ({1'b0, bit_count_reg} > (hsc_pkg::CNT_W + 1)'(i));
        end
    end

    // Encode: spread data over non-power-of-two positions, then fill parity
    always_comb begin
        enc_len  = hsc_pkg::ENC_LEN[bit_count_reg];
        enc_data = word_reg & count_mask;
        for (int i = 0; i < hsc_pkg::WORD_W; i++) begin
            enc_spread[i] = !hsc_pkg::PAR_MASK[i] && enc_data[hsc_pkg::POS_TO_DATA[i]];
        end
        enc_word = enc_spread;
        for (int k = 0; k < hsc_pkg::PAR_W; k++) begin
            enc_word[(1 << k) - 1] = ^(enc_spread & hsc_pkg::COVER[k]);
        end
    end

    // Decode: syndrome, optional single-bit fix, then strip parity
    always_comb begin
        dec_len = hsc_pkg::DEC_LEN[bit_count_reg];
        dec_cw  = word_reg & count_mask;
        for (int k = 0; k < hsc_pkg::PAR_W; k++) begin
            dec_syn[k] = ^(dec_cw & hsc_pkg::COVER[k]);
        end
        dec_bad_syn = (dec_syn > bit_count_reg);
        for (int i = 0; i < hsc_pkg::WORD_W; i++) begin
            dec_flip[i] = correct_reg && !dec_bad_syn
                          && (dec_syn == hsc_pkg::syn_t'(i + 1));
        end
        dec_fixed = dec_cw ^ dec_flip;
        for (int d = 0; d < hsc_pkg::WORD_W; d++) begin
            dec_data[d] = hsc_pkg::DATA_HAS[d] && dec_fixed[hsc_pkg::DATA_POS[d]];
        end
    end

    always_comb begin
        result_word_next  = '0;
        result_bits_next  = '0;
        syndrome_next     = '0;
        error_seen_next   = 1'b0;
        bad_syndrome_next = 1'b0;
        bad_length_next   = 1'b0;
        case (kind_reg)
            hsc_pkg::KIND_ENCODE: begin
                if (enc_len == '0) begin
                    bad_length_next = 1'b1;
                end else begin
                    result_word_next = enc_word;
                    result_bits_next = enc_len;
                end
            end
            hsc_pkg::KIND_DECODE: begin
                if (dec_len == '0) begin
                    bad_length_next = 1'b1;
                end else begin
                    result_word_next  = dec_data;
                    result_bits_next  = dec_len;
                    syndrome_next     = dec_syn;
                    error_seen_next   = (dec_syn != '0);
                    bad_syndrome_next = dec_bad_syn;
                end
            end
            default: begin
                bad_length_next = 1'b1;
            end
        endcase
    end

    // Load a fresh beat only when the result register is free
    always_ff @(posedge aclk) begin
        if (advance) begin
            result_word_reg  <= result_word_next;
            result_bits_reg  <= result_bits_next;
            syndrome_reg     <= syndrome_next;
            error_seen_reg   <= error_seen_next;
            bad_syndrome_reg <= bad_syndrome_next;
            bad_length_reg   <= bad_length_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_word  = result_word_reg;
    assign m_result_bits  = result_bits_reg;
    assign m_syndrome     = syndrome_reg;
    assign m_error_seen   = error_seen_reg;
    assign m_bad_syndrome = bad_syndrome_reg;
    assign m_bad_length   = bad_length_reg;

endmodule

`default_nettype wire
